// ===== hw/rtl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// RTC snapshot decoder package
// Shared types, register B bit positions, calendar constants and the small
// helper functions used by the decode logic.
// ----------------------------------------------------------------------------
package rsd_pkg;

	// Register B bit positions and the PM flag bit of the hour byte.
	localparam int RSD_SB_BIN = 2;
	localparam int RSD_SB_H24 = 1;
	localparam int RSD_HOUR_PM = 7;

	localparam logic [3:0] RSD_BCD_MAX = 4'd9;
	localparam logic [7:0] RSD_PIVOT = 8'd80;
	localparam logic [7:0] RSD_CENT_LO = 8'd19;
	localparam logic [7:0] RSD_CENT_HI = 8'd99;
	localparam logic [6:0] RSD_CENT_1900 = 7'd19;
	localparam logic [6:0] RSD_CENT_2000 = 7'd20;
	localparam logic [13:0] RSD_YEAR_MIN = 14'd1900;
	localparam logic [13:0] RSD_YEAR_MAX = 14'd9999;
	localparam logic [7:0] RSD_HOUR12_MAX = 8'd12;
	localparam logic [7:0] RSD_HOUR_MAX = 8'd23;
	localparam logic [7:0] RSD_MINSEC_MAX = 8'd59;
	localparam logic [7:0] RSD_MONTH_MAX = 8'd12;

	typedef struct packed {
		logic [7:0] second_raw;
		logic [7:0] minute_raw;
		logic [7:0] hour_byte;
		logic [7:0] day_raw;
		logic [7:0] month_raw;
		logic [7:0] year_raw;
		logic [7:0] century_raw;
		logic [7:0] status_b;
	} rsd_raw_t;

	typedef struct packed {
		logic        valid_res;
		logic [13:0] full_year;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
	} rsd_time_t;

	function automatic logic field_ok(input logic [7:0] b, input logic bin);
		return bin || ((b[3:0] <= RSD_BCD_MAX) && (b[7:4] <= RSD_BCD_MAX));
	endfunction

	// Tens digit times ten is formed as times eight plus times two.
	function automatic logic [7:0] field_val(input logic [7:0] b, input logic bin);
		logic [7:0] hi;
		hi = {4'd0, b[7:4]};
		return bin ? b : ((hi << 3) + (hi << 1) + {4'd0, b[3:0]});
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== hw/rtl/rtc_snapshot_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// RTC snapshot decoder unit
// Turns one raw CMOS clock snapshot into a checked calendar time.
// ----------------------------------------------------------------------------
// A request is held in the input register, decoded, and then held in the result
// register, from which its result is offered.
// Throughput: one request per cycle; a waiting result blocks new requests
// only once the input register holds an item as well.
// Reset clears both stage valid flags; the data registers are not reset.
module rtc_snapshot_decoder_unit
	import rsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// second_raw, minute_raw, hour_byte, day_raw, month_raw, year_raw, century_raw
	input  logic [55:0] s_axis_tdata,
	// status_b
	input  logic [7:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// full_year, month_out, day_out, hour_out, minute_out, second_out
	output logic [39:0] m_axis_tdata,
	// valid_res
	output logic [0:0]  m_axis_tuser
);

	logic      valid_s1;
	logic      valid_s2;
	rsd_raw_t  raw_s1;
	rsd_time_t res_s2;
	rsd_time_t res_d;
	logic      adv_s1;
	logic      adv_s2;

	assign adv_s2 = !valid_s2 || m_axis_tready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			raw_s1.second_raw <= s_axis_tdata[7:0];
			raw_s1.minute_raw <= s_axis_tdata[15:8];
			raw_s1.hour_byte <= s_axis_tdata[23:16];
			raw_s1.day_raw <= s_axis_tdata[31:24];
			raw_s1.month_raw <= s_axis_tdata[39:32];
			raw_s1.year_raw <= s_axis_tdata[47:40];
			raw_s1.century_raw <= s_axis_tdata[55:48];
			raw_s1.status_b <= s_axis_tuser;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	rsd_decode u_decode (
		.raw (raw_s1),
		.res (res_d)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser = res_s2.valid_res;
	assign m_axis_tdata = {res_s2.second_out, res_s2.minute_out, res_s2.hour_out,
		res_s2.day_out, res_s2.month_out, res_s2.full_year};

	// An invalid result carries all-zero fields.
	a_zero_on_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 40'd0)
		else $error("invalid result with nonzero fields");

	// A valid result always lies inside the calendar range.
	a_range_on_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
		res_s2.month_out != 4'd0 && res_s2.month_out <= 4'd12 &&
		res_s2.day_out != 5'd0 && res_s2.hour_out <= 5'd23 &&
		res_s2.minute_out <= 6'd59 && res_s2.second_out <= 6'd59 &&
		res_s2.full_year >= RSD_YEAR_MIN && res_s2.full_year <= RSD_YEAR_MAX)
		else $error("valid result out of calendar range");

	// An accepted request occupies the input register on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted request lost at input register");

	// A decoded item moves into the result register when that register frees.
	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("decoded item lost between stages");

endmodule

// ===== hw/rtl/rsd_decode.sv =====
// ----------------------------------------------------------------------------
// RTC snapshot decode
// Combinational decode of one raw snapshot: BCD or binary fields, 12- or
// 24-hour conversion, century resolution and the calendar range check.
// ----------------------------------------------------------------------------
module rsd_decode
	import rsd_pkg::*;
(
	input  rsd_raw_t  raw,
	output rsd_time_t res
);

	logic        bin;
	logic        h24;
	logic        pm;
	logic [7:0]  hr_m;
	logic        digits_ok;
	logic [7:0]  sec_v;
	logic [7:0]  min_v;
	logic [7:0]  hour_d;
	logic [7:0]  day_v;
	logic [7:0]  mon_v;
	logic [7:0]  yr_v;
	logic [7:0]  cen_v;
	logic        hr12_bad;
	logic [7:0]  hour_v;
	logic        cent_ok;
	logic [6:0]  cbase;
	logic [1:0]  yr_hund;
	logic [7:0]  yr_sub;
	logic [6:0]  yr_mod;
	logic [6:0]  cent_full;
	logic [13:0] year;
	logic        leap;
	logic        range_ok;
	logic        day_ok;
	logic        ok;

	always_comb begin
		bin = raw.status_b[RSD_SB_BIN];
		h24 = raw.status_b[RSD_SB_H24];
		pm = !h24 && raw.hour_byte[RSD_HOUR_PM];
		hr_m = h24 ? raw.hour_byte : {1'b0, raw.hour_byte[6:0]};

		digits_ok = field_ok(raw.second_raw, bin) && field_ok(raw.minute_raw, bin) &&
			field_ok(hr_m, bin) && field_ok(raw.day_raw, bin) &&
			field_ok(raw.month_raw, bin) && field_ok(raw.year_raw, bin);

		sec_v = field_val(raw.second_raw, bin);
		min_v = field_val(raw.minute_raw, bin);
		hour_d = field_val(hr_m, bin);
		day_v = field_val(raw.day_raw, bin);
		mon_v = field_val(raw.month_raw, bin);
		yr_v = field_val(raw.year_raw, bin);
		cen_v = field_val(raw.century_raw, bin);

		// Twelve o'clock maps to zero before the PM offset is applied.
		hr12_bad = !h24 && ((hour_d == 8'd0) || (hour_d > RSD_HOUR12_MAX));
		if (h24) begin
			hour_v = hour_d;
		end else begin
			hour_v = ((hour_d == RSD_HOUR12_MAX) ? 8'd0 : hour_d) +
				(pm ? RSD_HOUR12_MAX : 8'd0);
		end

		cent_ok = (raw.century_raw != 8'd0) && field_ok(raw.century_raw, bin) &&
			(cen_v >= RSD_CENT_LO) && (cen_v <= RSD_CENT_HI);
		if (cent_ok) begin
			cbase = cen_v[6:0];
		end else begin
			cbase = (yr_v >= RSD_PIVOT) ? RSD_CENT_1900 : RSD_CENT_2000;
		end

		// The year is cbase*100 + yr_v; a binary year byte can exceed 99, so the
		// hundreds it carries are split off for the leap test.
		if (yr_v >= 8'd200) begin
			yr_hund = 2'd2;
			yr_sub = yr_v - 8'd200;
		end else if (yr_v >= 8'd100) begin
			yr_hund = 2'd1;
			yr_sub = yr_v - 8'd100;
		end else begin
			yr_hund = 2'd0;
			yr_sub = yr_v;
		end
		yr_mod = yr_sub[6:0];
		cent_full = cbase + {5'd0, yr_hund};
		year = ({7'd0, cbase} * 14'd100) + {6'd0, yr_v};

		leap = ((year[1:0] == 2'd0) && (yr_mod != 7'd0)) ||
			((yr_mod == 7'd0) && (cent_full[1:0] == 2'd0));

		range_ok = (year >= RSD_YEAR_MIN) && (year <= RSD_YEAR_MAX) &&
			(mon_v != 8'd0) && (mon_v <= RSD_MONTH_MAX) && (hour_v <= RSD_HOUR_MAX) &&
			(min_v <= RSD_MINSEC_MAX) && (sec_v <= RSD_MINSEC_MAX);
		day_ok = (day_v != 8'd0) && (day_v <= {3'd0, month_len(mon_v[3:0], leap)});

		ok = digits_ok && !hr12_bad && range_ok && day_ok;

		res = '0;
		if (ok) begin
			res.valid_res = 1'b1;
			res.full_year = year;
			res.month_out = mon_v[3:0];
			res.day_out = day_v[4:0];
			res.hour_out = hour_v[4:0];
			res.minute_out = min_v[5:0];
			res.second_out = sec_v[5:0];
		end
	end

endmodule
